// ===== hdl/ptcs_pkg.sv =====
// Package for the plain-text charset sniffer: cell flags, result codes,
// byte-order-mark bytes and the character classification helpers.
// No dependencies.
package ptcs_pkg;

    localparam int LOOKAHEAD_MARGIN = 4;

    typedef logic [3:0] cell_t;
    typedef logic [2:0] class_t;

    localparam int CELL_START_BIT = 0;
    localparam int CELL_BAD_BIT   = 1;
    localparam int CELL_NUL_BIT   = 2;
    localparam int CELL_CTL_BIT   = 3;

    localparam cell_t CELL_NONE = 4'b0000;
    localparam cell_t CELL_START = 4'b0001;
    localparam cell_t CELL_BAD   = 4'b0010;
    localparam cell_t CELL_NUL   = 4'b0100;
    localparam cell_t CELL_CTL   = 4'b1000;

    localparam class_t CLS_ASCII     = 3'd0;
    localparam class_t CLS_UTF8_BOM  = 3'd1;
    localparam class_t CLS_UTF16_BOM = 3'd2;
    localparam class_t CLS_UTF8      = 3'd3;
    localparam class_t CLS_NOT_TEXT  = 3'd4;

    localparam logic [7:0] BOM8_0  = 8'hEF;
    localparam logic [7:0] BOM8_1  = 8'hBB;
    localparam logic [7:0] BOM8_2  = 8'hBF;
    localparam logic [7:0] BOM16_A = 8'hFE;
    localparam logic [7:0] BOM16_B = 8'hFF;

    localparam logic [7:0]  CH_TAB = 8'd9;
    localparam logic [7:0]  CH_LF  = 8'd10;
    localparam logic [7:0]  CH_CR  = 8'd13;
    localparam logic [15:0] SCAN_LIMIT_RESET = 16'd1024;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    function automatic logic is_ctl(input logic [20:0] v);
        logic r;
        r = (v != 21'd0) && (v < 21'd32) && (v != 21'(CH_TAB))
            && (v != 21'(CH_LF)) && (v != 21'(CH_CR));
        return r;
    endfunction

    function automatic cell_t classify_value(input logic [20:0] v);
        cell_t r;
        if (v == 21'd0) begin
            r = CELL_NUL;
        end else if (is_ctl(v)) begin
            r = CELL_CTL;
        end else begin
            r = CELL_NONE;
        end
        return r;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        logic [15:0] r;
        r = (v == COUNT_MAX) ? v : v + 16'd1;
        return r;
    endfunction

    // count * 100 <= len, the same as count <= len / 100
    function automatic logic under_limit(input logic [15:0] cnt, input logic [31:0] len);
        logic [22:0] x100;
        x100 = {1'b0, cnt, 6'b0} + {2'b0, cnt, 5'b0} + {5'b0, cnt, 2'b0};
        return {9'b0, x100} <= len;
    endfunction

endpackage

// ===== hdl/plain_text_charset_sniffer.sv =====
// Top level of the plain-text charset sniffer: byte check, UTF-8 decoder
// and classifier in one pass. Depends on ptcs_pkg.
//
// Usage: bytes of a buffer arrive on the s_ channel (s_data_byte, with
// s_last_byte on the final beat and s_total_length carried with it). Only
// the first scan_limit bytes feed the checks; later bytes only advance the
// position and BOM head bytes. The beat that carries s_last_byte yields one
// m_charset_class beat: 0 ASCII, 1 UTF-8 by BOM, 2 UTF-16 by BOM, 3 decoded
// UTF-8, 4 not text. Afterwards all buffer state clears for the next buffer.
// Throughput is one byte per cycle while s_ready is high; the result
// appears in m_charset_class in the cycle after the last byte is taken,
// from the output register. s_ready drops only while a result is held in
// the output register and the receiver stalls it; a waiting result is never
// overwritten. cfg_valid/cfg_data write scan_limit (reset 1024); cfg_ready
// is always high. The user makes writes while the block is idle; unenforced.
// Reset (aresetn low, synchronous) clears m_valid and all state but class_reg.
module plain_text_charset_sniffer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    input  logic [31:0] s_total_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_charset_class
);

    logic [15:0]          scan_limit_reg;
    logic [15:0]          pos_reg, pos_next;
    logic                 aok_reg, aok_next;
    logic                 anul_reg, anul_next;
    logic [15:0]          actl_reg, actl_next;
    logic [7:0]           head_reg [3];
    logic [7:0]           head_next [3];
    logic [1:0]           rem_reg, rem_next;
    logic [20:0]          cp_reg, cp_next;
    ptcs_pkg::cell_t      cell_reg [ptcs_pkg::LOOKAHEAD_MARGIN];
    ptcs_pkg::cell_t      cell_next [ptcs_pkg::LOOKAHEAD_MARGIN];
    logic                 uinv_reg, uinv_next;
    logic                 unul_reg, unul_next;
    logic [15:0]          uctl_reg, uctl_next;
    logic                 m_valid_reg, m_valid_next;
    ptcs_pkg::class_t     class_reg, class_next;

    logic                 s_fire;
    logic                 halted;
    ptcs_pkg::cell_t      old_cell;
    ptcs_pkg::cell_t      flag;
    logic [20:0]          cp_new;

    assign cfg_ready       = 1'b1;
    assign s_ready         = !m_valid_reg || m_ready;
    assign s_fire          = s_valid && s_ready;
    assign m_valid         = m_valid_reg;
    assign m_charset_class = class_reg;

    always_comb begin
        pos_next  = pos_reg;
        aok_next  = aok_reg;
        anul_next = anul_reg;
        actl_next = actl_reg;
        head_next = head_reg;
        rem_next  = rem_reg;
        cp_next   = cp_reg;
        cell_next = cell_reg;
        uinv_next = uinv_reg;
        unul_next = unul_reg;
        uctl_next = uctl_reg;
        class_next = class_reg;
        m_valid_next = m_valid_reg && !m_ready;
        halted   = 1'b0;
        old_cell = cell_reg[ptcs_pkg::LOOKAHEAD_MARGIN-1];
        flag     = ptcs_pkg::CELL_NONE;
        cp_new   = {cp_reg[14:0], s_data_byte[5:0]};

        if (s_fire) begin
            if (pos_reg < 16'd3) begin
                head_next[pos_reg[1:0]] = s_data_byte;
            end
            if (pos_reg < scan_limit_reg) begin
                if (s_data_byte == 8'd0) begin
                    anul_next = 1'b1;
                end else if (ptcs_pkg::is_ctl({13'd0, s_data_byte})) begin
                    actl_next = ptcs_pkg::sat_inc(actl_reg);
                end
                if (s_data_byte[7]) begin
                    aok_next = 1'b0;
                end

                if (old_cell[ptcs_pkg::CELL_START_BIT]) begin
                    if (old_cell[ptcs_pkg::CELL_BAD_BIT]) uinv_next = 1'b1;
                    if (old_cell[ptcs_pkg::CELL_NUL_BIT]) unul_next = 1'b1;
                    if (old_cell[ptcs_pkg::CELL_CTL_BIT]) begin
                        uctl_next = ptcs_pkg::sat_inc(uctl_reg);
                    end
                end
                for (int i = ptcs_pkg::LOOKAHEAD_MARGIN - 1; i > 0; i--) begin
                    cell_next[i] = cell_reg[i-1];
                end
                cell_next[0] = ptcs_pkg::CELL_NONE;

                halted = uinv_next;
                for (int i = 1; i < ptcs_pkg::LOOKAHEAD_MARGIN; i++) begin
                    halted = halted | cell_next[i][ptcs_pkg::CELL_BAD_BIT];
                end

                if (halted) begin
                    rem_next = 2'd0;
                end else if (rem_reg != 2'd0) begin
                    if (s_data_byte[7:6] == 2'b10) begin
                        cp_next  = cp_new;
                        rem_next = rem_reg - 2'd1;
                        if (rem_reg == 2'd1) begin
                            flag = ptcs_pkg::classify_value(cp_new);
                        end
                    end else begin
                        flag     = ptcs_pkg::CELL_BAD;
                        rem_next = 2'd0;
                    end
                    if (cell_next[1][ptcs_pkg::CELL_START_BIT]) begin
                        cell_next[1] = cell_next[1] | flag;
                    end else if (cell_next[2][ptcs_pkg::CELL_START_BIT]) begin
                        cell_next[2] = cell_next[2] | flag;
                    end else begin
                        cell_next[3] = cell_next[3] | flag;
                    end
                end else begin
                    cell_next[0] = ptcs_pkg::CELL_START;
                    if (!s_data_byte[7]) begin
                        cell_next[0] = ptcs_pkg::CELL_START
                            | ptcs_pkg::classify_value({13'd0, s_data_byte});
                    end else if (s_data_byte[7:5] == 3'b110) begin
                        cp_next  = {16'd0, s_data_byte[4:0]};
                        rem_next = 2'd1;
                    end else if (s_data_byte[7:4] == 4'b1110) begin
                        cp_next  = {17'd0, s_data_byte[3:0]};
                        rem_next = 2'd2;
                    end else if (s_data_byte[7:3] == 5'b11110) begin
                        cp_next  = {18'd0, s_data_byte[2:0]};
                        rem_next = 2'd3;
                    end else begin
                        cell_next[0] = ptcs_pkg::CELL_START | ptcs_pkg::CELL_BAD;
                    end
                end
            end
            pos_next = ptcs_pkg::sat_inc(pos_reg);

            if (s_last_byte) begin
                if (aok_next && !anul_next
                    && ptcs_pkg::under_limit(actl_next, s_total_length)) begin
                    class_next = ptcs_pkg::CLS_ASCII;
                end else if (s_total_length >= 32'd3 && head_next[0] == ptcs_pkg::BOM8_0
                    && head_next[1] == ptcs_pkg::BOM8_1
                    && head_next[2] == ptcs_pkg::BOM8_2) begin
                    class_next = ptcs_pkg::CLS_UTF8_BOM;
                end else if (s_total_length >= 32'd2
                    && ((head_next[0] == ptcs_pkg::BOM16_A && head_next[1] == ptcs_pkg::BOM16_B)
                    || (head_next[0] == ptcs_pkg::BOM16_B
                        && head_next[1] == ptcs_pkg::BOM16_A))) begin
                    class_next = ptcs_pkg::CLS_UTF16_BOM;
                end else if (!uinv_next && !unul_next
                    && ptcs_pkg::under_limit(uctl_next, s_total_length)) begin
                    class_next = ptcs_pkg::CLS_UTF8;
                end else begin
                    class_next = ptcs_pkg::CLS_NOT_TEXT;
                end
                m_valid_next = 1'b1;

                pos_next  = 16'd0;
                aok_next  = 1'b1;
                anul_next = 1'b0;
                actl_next = 16'd0;
                for (int i = 0; i < 3; i++) head_next[i] = 8'd0;
                rem_next  = 2'd0;
                cp_next   = 21'd0;
                for (int i = 0; i < ptcs_pkg::LOOKAHEAD_MARGIN; i++) begin
                    cell_next[i] = ptcs_pkg::CELL_NONE;
                end
                uinv_next = 1'b0;
                unul_next = 1'b0;
                uctl_next = 16'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_limit_reg <= ptcs_pkg::SCAN_LIMIT_RESET;
            pos_reg  <= 16'd0;
            aok_reg  <= 1'b1;
            anul_reg <= 1'b0;
            actl_reg <= 16'd0;
            for (int i = 0; i < 3; i++) head_reg[i] <= 8'd0;
            rem_reg  <= 2'd0;
            cp_reg   <= 21'd0;
            for (int i = 0; i < ptcs_pkg::LOOKAHEAD_MARGIN; i++) begin
                cell_reg[i] <= ptcs_pkg::CELL_NONE;
            end
            uinv_reg <= 1'b0;
            unul_reg <= 1'b0;
            uctl_reg <= 16'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                scan_limit_reg <= cfg_data;
            end
            pos_reg  <= pos_next;
            aok_reg  <= aok_next;
            anul_reg <= anul_next;
            actl_reg <= actl_next;
            head_reg <= head_next;
            rem_reg  <= rem_next;
            cp_reg   <= cp_next;
            cell_reg <= cell_next;
            uinv_reg <= uinv_next;
            unul_reg <= unul_next;
            uctl_reg <= uctl_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        class_reg <= class_next;
    end

endmodule

// ===== hdl/ptcs_checker.sv =====
// Port-level checker for plain_text_charset_sniffer, attached by bind.
// Depends on ptcs_pkg.
module ptcs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_last_byte,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_charset_class
);

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_byte
        |=> m_valid && m_charset_class <= ptcs_pkg::CLS_NOT_TEXT)
        else $error("last beat did not yield a valid result");

    a_no_phantom_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_valid && s_ready && s_last_byte) && !(m_valid && !m_ready) |=> !m_valid)
        else $error("result without a last beat");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result stalled");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_charset_class))
        else $error("stalled result changed");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind plain_text_charset_sniffer ptcs_checker u_ptcs_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_last_byte     (s_last_byte),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_charset_class (m_charset_class)
);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for plain_text_charset_sniffer: ASCII, UTF-8, BOM-led,
// broken and random buffers under several scan limits, with a scoreboard that
// predicts each charset class. Depends on ptcs_pkg and the block's RTL.
module tb;

    localparam int          CLK_HALF     = 2;
    localparam int unsigned RANDOM_BYTES = 750;
    localparam int unsigned CYCLE_LIMIT  = 1_500_000;

    class charset_scoreboard;
        logic [15:0] scan_limit;
        logic [15:0] position;
        bit          plain_ok;
        bit          plain_nul;
        logic [15:0] plain_ctl;
        logic [7:0]  head [3];
        int unsigned cont_left;
        logic [20:0] code_point;
        ptcs_pkg::cell_t cells [ptcs_pkg::LOOKAHEAD_MARGIN];
        bit          dec_bad;
        bit          dec_nul;
        logic [15:0] dec_ctl;
        ptcs_pkg::class_t expected_classes [$];
        int unsigned errors;
        int unsigned beats;
        int unsigned buffers;
        int unsigned class_hits [5];

        function new();
            scan_limit = ptcs_pkg::SCAN_LIMIT_RESET;
            errors = 0;
            beats = 0;
            buffers = 0;
            foreach (class_hits[i]) class_hits[i] = 0;
            clear_buffer();
        endfunction

        function void clear_buffer();
            position = '0;
            plain_ok = 1'b1;
            plain_nul = 1'b0;
            plain_ctl = '0;
            foreach (head[i]) head[i] = '0;
            cont_left = 0;
            code_point = '0;
            foreach (cells[i]) cells[i] = ptcs_pkg::CELL_NONE;
            dec_bad = 1'b0;
            dec_nul = 1'b0;
            dec_ctl = '0;
        endfunction

        function bit is_control(logic [20:0] v);
            return v != 0 && v < 32 && v != ptcs_pkg::CH_TAB && v != ptcs_pkg::CH_LF
                && v != ptcs_pkg::CH_CR;
        endfunction

        function ptcs_pkg::cell_t value_flags(logic [20:0] v);
            if (v == 0) return ptcs_pkg::CELL_NUL;
            return is_control(v) ? ptcs_pkg::CELL_CTL : ptcs_pkg::CELL_NONE;
        endfunction

        function logic [15:0] bump(logic [15:0] v);
            return (v == ptcs_pkg::COUNT_MAX) ? v : v + 16'd1;
        endfunction

        function void report(string msg);
            errors++;
            $display("ERROR at %0t: %s", $time, msg);
        endfunction

        // one byte inside the scan window: byte check and UTF-8 decoder
        function void absorb_byte(logic [7:0] b);
            ptcs_pkg::cell_t oldest;
            bit    halted;
            int    s;
            int    i;
            oldest = cells[ptcs_pkg::LOOKAHEAD_MARGIN - 1];
            if (b == 8'd0) plain_nul = 1'b1;
            else if (is_control({13'd0, b})) plain_ctl = bump(plain_ctl);
            if (b[7]) plain_ok = 1'b0;
            // commit the character that left the lookahead window
            if (oldest[ptcs_pkg::CELL_START_BIT]) begin
                if (oldest[ptcs_pkg::CELL_BAD_BIT]) dec_bad = 1'b1;
                if (oldest[ptcs_pkg::CELL_NUL_BIT]) dec_nul = 1'b1;
                if (oldest[ptcs_pkg::CELL_CTL_BIT]) dec_ctl = bump(dec_ctl);
            end
            for (i = ptcs_pkg::LOOKAHEAD_MARGIN - 1; i > 0; i--) cells[i] = cells[i - 1];
            cells[0] = ptcs_pkg::CELL_NONE;
            halted = dec_bad;
            foreach (cells[k]) if (cells[k][ptcs_pkg::CELL_BAD_BIT]) halted = 1'b1;
            if (halted) begin
                cont_left = 0;
                return;
            end
            if (cont_left != 0) begin
                s = 1;
                while (s < ptcs_pkg::LOOKAHEAD_MARGIN - 1
                       && !cells[s][ptcs_pkg::CELL_START_BIT]) s++;
                if (b[7:6] == 2'b10) begin
                    code_point = {code_point[14:0], b[5:0]};
                    cont_left--;
                    if (cont_left == 0) cells[s] |= value_flags(code_point);
                end else begin
                    cells[s] |= ptcs_pkg::CELL_BAD;
                    cont_left = 0;
                end
                return;
            end
            cells[0] = ptcs_pkg::CELL_START;
            if (!b[7]) begin
                cells[0] |= value_flags({13'd0, b});
            end else if (b[7:5] == 3'b110) begin
                code_point = {16'd0, b[4:0]};
                cont_left = 1;
            end else if (b[7:4] == 4'b1110) begin
                code_point = {17'd0, b[3:0]};
                cont_left = 2;
            end else if (b[7:3] == 5'b11110) begin
                code_point = {18'd0, b[2:0]};
                cont_left = 3;
            end else begin
                cells[0] |= ptcs_pkg::CELL_BAD;
            end
        endfunction

        function void note_byte(logic [7:0] b, bit last, logic [31:0] len);
            logic [31:0] ctl_limit;
            ptcs_pkg::class_t cls;
            beats++;
            if (position < 3) head[position] = b;
            if (position < scan_limit) absorb_byte(b);
            position = bump(position);
            if (!last) return;
            ctl_limit = len / 100;
            if (plain_ok && !plain_nul && {16'd0, plain_ctl} <= ctl_limit) begin
                cls = ptcs_pkg::CLS_ASCII;
            end else if (len >= 3 && head[0] == ptcs_pkg::BOM8_0
                         && head[1] == ptcs_pkg::BOM8_1
                         && head[2] == ptcs_pkg::BOM8_2) begin
                cls = ptcs_pkg::CLS_UTF8_BOM;
            end else if (len >= 2
                         && ((head[0] == ptcs_pkg::BOM16_A && head[1] == ptcs_pkg::BOM16_B)
                         || (head[0] == ptcs_pkg::BOM16_B
                             && head[1] == ptcs_pkg::BOM16_A))) begin
                cls = ptcs_pkg::CLS_UTF16_BOM;
            end else if (!dec_bad && !dec_nul && {16'd0, dec_ctl} <= ctl_limit) begin
                cls = ptcs_pkg::CLS_UTF8;
            end else begin
                cls = ptcs_pkg::CLS_NOT_TEXT;
            end
            expected_classes.push_back(cls);
            buffers++;
            clear_buffer();
        endfunction

        function void check_class(ptcs_pkg::class_t got);
            ptcs_pkg::class_t want;
            if (expected_classes.size() == 0) begin
                report($sformatf("class %0d arrived with no buffer pending", got));
                return;
            end
            want = expected_classes.pop_front();
            if (got !== want) begin
                report($sformatf("buffer %0d: class %0d, predicted %0d",
                                 buffers - expected_classes.size(), got, want));
            end else begin
                class_hits[want]++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        s_last_byte = 1'b0;
    logic [31:0] s_total_length = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_charset_class;

    charset_scoreboard sb;
    logic [7:0]  text_bytes [$];
    int unsigned cycle_count = 0;
    int unsigned rx_tick = 0;
    int unsigned rx_mode = 0;
    int unsigned burst_left = 0;
    int unsigned limit_writes = 0;
    bit          no_gaps = 1'b0;

    plain_text_charset_sniffer uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_last_byte     (s_last_byte),
        .s_total_length  (s_total_length),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_charset_class (m_charset_class)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ERROR: no progress after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.scan_limit = cfg_data;
            if (s_valid && s_ready) sb.note_byte(s_data_byte, s_last_byte, s_total_length);
            if (m_valid && m_ready) sb.check_class(m_charset_class);
        end
    end

    always @(negedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % 97 == 0) rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= (rx_tick % 3) == 0;
            2: m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= $urandom_range(0, 7) != 0;
        endcase
    end

    task automatic send_beat(input logic [7:0] b, input bit last, input logic [31:0] len);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (no_gaps || $urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                @(negedge aclk);
                s_valid = 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid = 1'b1;
        s_data_byte = b;
        s_last_byte = last;
        s_total_length = len;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
    endtask

    task automatic send_text(input logic [31:0] len);
        int unsigned n;
        n = text_bytes.size();
        for (int unsigned i = 0; i < n; i++) begin
            send_beat(text_bytes[i], i == n - 1, (i == n - 1) ? len : $urandom());
        end
        text_bytes.delete();
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.expected_classes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_scan_limit(input logic [15:0] v);
        wait_for_results();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data = v;
        forever begin
            @(posedge aclk);
            if (cfg_ready) break;
        end
        @(negedge aclk);
        cfg_valid = 1'b0;
        cfg_data = 16'($urandom());
        limit_writes++;
    endtask

    function automatic logic [31:0] pick_total_length(input int unsigned n);
        case ($urandom_range(0, 19))
            0, 1:    return $urandom();
            2, 3, 4: return $urandom_range(0, 600);
            5:       return $urandom_range(0, 3);
            default: return n;
        endcase
    endfunction

    function automatic void add_ascii(input int unsigned n, input bit dirty);
        repeat (n) begin
            if (dirty && $urandom_range(0, 9) < 2) begin
                text_bytes.push_back(8'($urandom_range(0, 31)));
            end else if ($urandom_range(0, 9) == 0) begin
                text_bytes.push_back(ptcs_pkg::CH_LF);
            end else begin
                text_bytes.push_back(8'($urandom_range(8'h20, 8'h7F)));
            end
        end
    endfunction

    // dirty characters lean on overlong forms that decode to code points below 32
    function automatic void add_utf8_char(input bit dirty);
        logic [7:0] cont;
        cont = {2'b10, 6'($urandom())};
        if (dirty && $urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 2))
                0: text_bytes.push_back(8'hC0);
                1: begin
                    text_bytes.push_back(8'hE0);
                    text_bytes.push_back(8'h80);
                end
                default: begin
                    text_bytes.push_back(8'hF0);
                    text_bytes.push_back(8'h80);
                    text_bytes.push_back(8'h80);
                end
            endcase
            text_bytes.push_back({3'b100, 5'($urandom())});
            return;
        end
        case ($urandom_range(1, 4))
            1: add_ascii(1, dirty);
            2: begin
                text_bytes.push_back({3'b110, 5'($urandom())});
                text_bytes.push_back(cont);
            end
            3: begin
                text_bytes.push_back({4'b1110, 4'($urandom())});
                text_bytes.push_back(cont);
                text_bytes.push_back({2'b10, 6'($urandom())});
            end
            default: begin
                text_bytes.push_back({5'b11110, 3'($urandom())});
                text_bytes.push_back(cont);
                text_bytes.push_back({2'b10, 6'($urandom())});
                text_bytes.push_back({2'b10, 6'($urandom())});
            end
        endcase
    endfunction

    function automatic void add_broken();
        case ($urandom_range(0, 3))
            0: text_bytes.push_back({2'b10, 6'($urandom())});
            1: text_bytes.push_back({5'b11111, 3'($urandom())});
            2: begin
                text_bytes.push_back({3'b110, 5'($urandom())});
                add_ascii(1, 1'b0);
            end
            default: begin
                text_bytes.push_back({4'b1110, 4'($urandom())});
                text_bytes.push_back({2'b10, 6'($urandom())});
                text_bytes.push_back({1'b1, 1'b1, 6'($urandom())});
            end
        endcase
    endfunction

    function automatic void add_random(input int unsigned n);
        repeat (n) text_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    task automatic send_random_buffer();
        int unsigned kind;
        int unsigned n;
        kind = $urandom_range(0, 99);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        if (kind < 25) begin
            add_ascii(n, 1'b0);
        end else if (kind < 35) begin
            add_ascii(n, 1'b1);
        end else if (kind < 60) begin
            repeat (n) add_utf8_char(1'b0);
        end else if (kind < 68) begin
            repeat (n) add_utf8_char($urandom_range(0, 3) == 0);
        end else if (kind < 75) begin
            text_bytes.push_back(ptcs_pkg::BOM8_0);
            if ($urandom_range(0, 4) != 0) text_bytes.push_back(ptcs_pkg::BOM8_1);
            if ($urandom_range(0, 4) != 0) text_bytes.push_back(ptcs_pkg::BOM8_2);
            repeat (n) add_utf8_char($urandom_range(0, 3) == 0);
        end else if (kind < 82) begin
            if ($urandom_range(0, 1)) begin
                text_bytes.push_back(ptcs_pkg::BOM16_A);
                text_bytes.push_back(ptcs_pkg::BOM16_B);
            end else begin
                text_bytes.push_back(ptcs_pkg::BOM16_B);
                text_bytes.push_back(ptcs_pkg::BOM16_A);
            end
            add_random(n);
        end else if (kind < 92) begin
            repeat (n / 2) add_utf8_char(1'b0);
            add_broken();
            repeat (n - n / 2) begin
                if ($urandom_range(0, 3) == 0) add_broken();
                else add_utf8_char(1'b0);
            end
        end else begin
            add_random(n);
        end
        send_text(pick_total_length(text_bytes.size()));
    endtask

    initial begin
        int unsigned start_beats;
        int unsigned buffer_count;
        int unsigned choice;
        sb = new();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed buffers at the reset scan limit
        text_bytes = {8'h41};
        send_text(32'd1);
        text_bytes = {8'h00};
        send_text(32'd1);
        text_bytes = {ptcs_pkg::BOM8_0, ptcs_pkg::BOM8_1, ptcs_pkg::BOM8_2};
        send_text(32'd3);
        text_bytes = {ptcs_pkg::BOM16_B, ptcs_pkg::BOM16_A};
        send_text(32'd2);
        text_bytes = {ptcs_pkg::BOM16_A, ptcs_pkg::BOM16_B};
        send_text(32'd1);
        text_bytes = {8'hC3, 8'hA9, 8'h41, 8'h41, 8'h41, 8'h41};
        send_text(32'd6);
        text_bytes = {8'h80, 8'h41, 8'h41, 8'h41, 8'h41};
        send_text(32'd5);
        text_bytes = {8'h1F};
        send_text(32'hFFFF_FFFF);
        text_bytes = {8'hC0, 8'h80, 8'h41, 8'h41, 8'h41};
        send_text(32'd5);

        // head bytes still captured past a one-byte window
        write_scan_limit(16'd1);
        text_bytes = {ptcs_pkg::BOM16_B, ptcs_pkg::BOM16_A, 8'h41};
        send_text(32'd3);

        start_beats = sb.beats;
        buffer_count = 0;
        while (sb.beats - start_beats < RANDOM_BYTES) begin
            if (buffer_count % 15 == 0) begin
                choice = $urandom_range(0, 9);
                case (choice)
                    0: write_scan_limit(16'd1);
                    1: write_scan_limit(16'hFFFF);
                    2: write_scan_limit(ptcs_pkg::SCAN_LIMIT_RESET);
                    3: write_scan_limit(16'($urandom_range(1, 16'hFFFF)));
                    default: write_scan_limit(16'($urandom_range(2, 24)));
                endcase
                no_gaps = $urandom_range(0, 3) == 0;
            end else if ($urandom_range(0, 9) == 0) begin
                wait_for_results();
            end
            send_random_buffer();
            buffer_count++;
        end

        wait_for_results();
        repeat (8) @(posedge aclk);
        if (sb.expected_classes.size() != 0) begin
            sb.report($sformatf("%0d classes never arrived", sb.expected_classes.size()));
        end
        $display("summary: %0d bytes in %0d buffers over %0d scan-limit settings",
                 sb.beats, sb.buffers, limit_writes + 1);
        $display("summary: ascii %0d, utf8 bom %0d, utf16 bom %0d, utf8 %0d, not text %0d",
                 sb.class_hits[ptcs_pkg::CLS_ASCII], sb.class_hits[ptcs_pkg::CLS_UTF8_BOM],
                 sb.class_hits[ptcs_pkg::CLS_UTF16_BOM], sb.class_hits[ptcs_pkg::CLS_UTF8],
                 sb.class_hits[ptcs_pkg::CLS_NOT_TEXT]);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ptcs_pkg.sv
hdl/plain_text_charset_sniffer.sv
hdl/ptcs_checker.sv
sim/tb.sv
